>>> src/hgs_pkg.sv
package hgs_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PART_W = 6;
  localparam logic [63:0] HASH_SEED = 64'd88172645463325252;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_ENTRIES - 1);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] sum;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic last;
  } emit_t;

  function automatic logic [ADDR_W-1:0] hgs_hash(input logic [63:0] k);
    logic [63:0] r;
    r = HASH_SEED ^ k;
    r = r ^ (r << 13);
    r = r ^ (r >> 7);
    r = r ^ (r << 17);
    return ADDR_W'(r & 64'(TABLE_ENTRIES - 1));
  endfunction

endpackage

>>> src/hgs_store.sv
module hgs_store
  import hgs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/hgs_ctrl.sv
module hgs_ctrl
  import hgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [63:0]       key,
  input  logic [63:0]       value,
  output logic              busy,
  output logic              we,
  output logic [ADDR_W-1:0] addr,
  output entry_t            wdata,
  input  entry_t            rdata,
  output emit_t             emit
);

  state_t                   state, state_next;
  logic [ADDR_W-1:0]        idx, idx_next;
  logic [FILL_W-1:0]        fill, fill_next;
  logic [TABLE_ENTRIES-1:0] valid, valid_next;
  logic [TABLE_ENTRIES-1:0] above;
  logic [63:0]              key_q, value_q;
  emit_t                    emit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      valid <= '0;
      emit  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      valid <= valid_next;
      emit  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == ST_IDLE && start) begin
      key_q   <= key;
      value_q <= value;
    end
  end

  assign above = valid >> idx;
  assign busy  = (state != ST_IDLE);
  assign addr  = idx;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    fill_next  = fill;
    valid_next = valid;
    emit_next  = '0;
    we         = 1'b0;
    wdata      = '{key: key_q, sum: value_q};
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func_t'(func) == FUNC_DRAIN) begin
            idx_next   = '0;
            state_next = ST_SCAN;
          end else begin
            idx_next   = hgs_hash(key);
            state_next = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (!valid[idx]) begin
          we              = 1'b1;
          valid_next[idx] = 1'b1;
          fill_next       = fill + FILL_W'(1);
          if (fill == FILL_W'(TABLE_ENTRIES - 1)) begin
            idx_next   = '0;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rdata.key == key_q) begin
          we         = 1'b1;
          wdata.sum  = rdata.sum + value_q;
          state_next = ST_IDLE;
        end else begin
          idx_next   = (idx == LAST_SLOT) ? '0 : idx + ADDR_W'(1);
          state_next = ST_PROBE;
        end
      end
      ST_SCAN: begin
        emit_next.valid = valid[idx];
        emit_next.last  = (above[TABLE_ENTRIES-1:1] == '0);
        if (idx == LAST_SLOT) begin
          valid_next = '0;
          fill_next  = '0;
          state_next = ST_DONE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/hash_group_by_sum_table.sv
// channel  | ports                                | handshake
// ---------+--------------------------------------+---------------------------
// input    | func, key, value                     | start high while busy low
// result   | out_key, out_sum, partition, last    | out_valid, one cycle each
//
// insert: the home slot is probed and written when empty; each occupied slot passed
// over costs a read then a compare, and a matching key has its sum written back.
// drain: a 64-slot scan with one memory read per cycle; a full table drains itself.
// at most one result per cycle during the scan, and results cannot be held off.
// synchronous reset clears the valid bits and the fill count at once.
module hash_group_by_sum_table
  import hgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [63:0]       key,
  input  logic [63:0]       value,
  output logic              out_valid,
  output logic [63:0]       out_key,
  output logic [63:0]       out_sum,
  output logic [PART_W-1:0] partition,
  output logic              last
);

  logic              we;
  logic [ADDR_W-1:0] addr;
  entry_t            wdata;
  entry_t            rdata;
  emit_t             emit;

  hgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .key   (key),
    .value (value),
    .busy  (busy),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata),
    .emit  (emit)
  );

  hgs_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign out_valid = emit.valid;
  assign last      = emit.valid & emit.last;
  assign out_key   = rdata.key;
  assign out_sum   = rdata.sum;
  assign partition = PART_W'(hgs_hash(rdata.key));

endmodule
